>>> hdl/static_linked_list_engine_top_macros.svh
// Assertion macros shared by the RTL of the linked list engine.
// Each macro samples on the rising edge of clock and is switched off while reset is high.
`ifndef STATIC_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_TOP_MACROS_SVH

// The condition holds at every edge.
`define SLL_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define SLL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds at the edge after the antecedent.
`define SLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/sll_pkg.sv
`default_nettype none

package sll_pkg;

   // Field widths of the request and response beats.
   localparam int CMD_W    = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   // Default number of slots, the head sentinel included.
   localparam int DEFAULT_CAPACITY = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   // Operation token that travels down the row of cells, one cell per cycle.
   // The skip count reaches zero at the addressed cell and stays there.
   typedef struct packed {
      logic              active;
      cmd_type           op;
      logic [POS_W-1:0]  skip;
      logic              held;
      logic [DATA_W-1:0] word;
   } token_type;

   // One finished result.
   typedef struct packed {
      logic              ok;
      status_type        status;
      logic [DATA_W-1:0] read_value;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/sll_cell.sv
`default_nettype none

module sll_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  sll_pkg::token_type           tok_i,
   output sll_pkg::token_type           tok_o,
   input  logic [sll_pkg::DATA_W-1:0]   right_data,
   output logic [sll_pkg::DATA_W-1:0]   data_o
);
   import sll_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   token_type         tok_ff;
   token_type         tok_in;
   logic              here;

   // The cell acts once the token's skip count has run down to zero.
   always_comb begin
      here    = (tok_i.skip == '0);
      data_in = data_ff;
      tok_in  = tok_i;
      if (!here) begin
         tok_in.skip = tok_i.skip - POS_W'(1);
      end
      if (tok_i.active && here) begin
         unique case (tok_i.op)
            CMD_INSERT: begin
               // Take the carried word and pass the old one to the right.
               data_in     = tok_i.word;
               tok_in.word = data_ff;
            end
            CMD_REMOVE: begin
               // Close the gap with the right neighbour's word.
               data_in = right_data;
            end
            CMD_READ: begin
               if (!tok_i.held) begin
                  tok_in.word = data_ff;
                  tok_in.held = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Reset clears the token register; the stored word is left as it is.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o  = tok_ff;
   assign data_o = data_ff;

endmodule

`default_nettype wire

>>> hdl/sll_ctrl.sv
`default_nettype none

`include "static_linked_list_engine_top_macros.svh"

module sll_ctrl #(
   parameter int CAPACITY = sll_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sll_pkg::CMD_W-1:0]       req_cmd,
   input  logic [sll_pkg::POS_W-1:0]       req_position,
   input  logic [sll_pkg::DATA_W-1:0]      req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [sll_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sll_pkg::DATA_W-1:0]      rsp_read_value,
   output sll_pkg::token_type              launch_o,
   input  sll_pkg::token_type              ret_i
);
   import sll_pkg::*;

   localparam int LEN_W = $clog2(CAPACITY);
   localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CAPACITY - 1);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   result_type       pend_ff, pend_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             go;
   logic             ins_pos_ok;
   logic             rd_pos_ok;
   logic             full;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] len_x;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Position checks against the current list length.
   assign pos_x      = CMP_W'(req_position);
   assign len_x      = CMP_W'(len_ff);
   assign ins_pos_ok = (pos_x != '0) && (pos_x <= len_x + CMP_W'(1));
   assign rd_pos_ok  = (pos_x != '0) && (pos_x <= len_x);
   assign full       = (len_ff == LEN_MAX);

   // Token handed to the first cell in the cycle of acceptance.
   always_comb begin
      launch_o.active = go;
      launch_o.op     = cmd_type'(req_cmd);
      launch_o.skip   = req_position - POS_W'(1);
      launch_o.held   = 1'b0;
      launch_o.word   = req_value;
   end

   // Next state, length bookkeeping and the pending result.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      go           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in.ok         = 1'b0;
               pend_in.status     = STATUS_BADPOS;
               pend_in.read_value = '0;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (ins_pos_ok && full) begin
                        pend_in.status = STATUS_FULL;
                     end else if (ins_pos_ok) begin
                        go     = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (rd_pos_ok) begin
                        go     = 1'b1;
                        len_in = len_ff - LEN_W'(1);
                     end
                  end
                  CMD_READ: begin
                     go = rd_pos_ok;
                  end
                  default: begin
                  end
               endcase
               state_in = go ? ST_WALK : ST_HOLD;
            end
         end
         ST_WALK: begin
            if (ret_i.active) begin
               pend_in.ok         = 1'b1;
               pend_in.status     = STATUS_DONE;
               pend_in.read_value = (ret_i.op == CMD_READ) ? ret_i.word : '0;
               state_in           = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers reset; result payloads do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ff.ok;
   assign rsp_status     = rsp_ff.status;
   assign rsp_read_value = rsp_ff.read_value;

   // Checks on the sequencing and the result encoding.
   `SLL_ASSERT_NOW(a_len_bound, len_ff <= LEN_MAX, "list length beyond the store")
   `SLL_ASSERT_SAME(a_ret_in_walk, ret_i.active, state_ff == ST_WALK, "stray token at the end")
   `SLL_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready, "request taken while busy")
   `SLL_ASSERT_SAME(a_ok_status, rsp_valid, rsp_ok == (rsp_status == STATUS_DONE), "ok and status disagree")
   `SLL_ASSERT_SAME(a_fail_zero, rsp_valid && !rsp_ok, rsp_read_value == '0, "failed beat with data")

endmodule

`default_nettype wire

>>> hdl/static_linked_list_engine_top.sv
// A request is taken only while the engine is idle; a rejected one (bad position, full store,
// unknown command) gets its result without entering the row, a successful one once its token
// has walked one cell per cycle down the row of CAPACITY-1 cells. A new request is not taken
// until the result of the last one has been registered on the response port.
// Reset (synchronous, active high) empties the list at once; no clearing pass.
`default_nettype none

module static_linked_list_engine_top #(
   parameter int CAPACITY = sll_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sll_pkg::CMD_W-1:0]       req_cmd,
   input  logic [sll_pkg::POS_W-1:0]       req_position,
   input  logic [sll_pkg::DATA_W-1:0]      req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic [sll_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sll_pkg::DATA_W-1:0]      rsp_read_value
);
   import sll_pkg::*;

   // One cell per data slot; the list is kept in position order along the row.
   localparam int NCELLS = CAPACITY - 1;

   token_type         chain [NCELLS:0];
   logic [DATA_W-1:0] cell_data [NCELLS:0];

   // Nothing lies beyond the last cell.
   assign cell_data[NCELLS] = '0;

   sll_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .launch_o       (chain[0]),
      .ret_i          (chain[NCELLS])
   );

   // Row of cells; each passes the token to its right neighbour every cycle.
   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      sll_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_i      (chain[i]),
         .tok_o      (chain[i+1]),
         .right_data (cell_data[i+1]),
         .data_o     (cell_data[i])
      );
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_static_linked_list_engine_top.sv
import sll_pkg::*;

// Mirror of the linked list: it predicts the response to every accepted request beat
// and holds the predictions until the matching response beats arrive.
class list_mirror #(parameter int SLOTS = DEFAULT_CAPACITY);

   localparam logic [POS_W-1:0] NULL_SLOT = '0;

   logic [POS_W-1:0]  slot_link [SLOTS];
   logic [DATA_W-1:0] slot_word [SLOTS];
   logic [POS_W-1:0]  free_top;
   int unsigned       next_fresh;
   int unsigned       node_count;
   int unsigned       fault_count;
   result_type        pending_results [$];

   function new();
      foreach (slot_link[i]) begin
         slot_link[i] = NULL_SLOT;
         slot_word[i] = '0;
      end
      free_top    = NULL_SLOT;
      next_fresh  = 1;
      node_count  = 0;
      fault_count = 0;
   endfunction

   // Follows a number of links from the sentinel; fails on meeting a null link early.
   function bit follow_links(int unsigned steps, output logic [POS_W-1:0] slot);
      logic [POS_W-1:0] cur;
      cur  = NULL_SLOT;
      slot = NULL_SLOT;
      for (int unsigned i = 0; i < steps; i++) begin
         if (slot_link[cur] == NULL_SLOT || slot_link[cur] >= SLOTS) return 1'b0;
         cur = slot_link[cur];
      end
      slot = cur;
      return 1'b1;
   endfunction

   // Applies one accepted request to the mirror and queues the response it should give.
   function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] word);
      result_type       res;
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] slot;
      res.ok         = 1'b0;
      res.status     = STATUS_BADPOS;
      res.read_value = '0;
      prev           = NULL_SLOT;
      slot           = NULL_SLOT;
      case (cmd)
         CMD_INSERT: begin
            if (pos >= 1 && follow_links(pos - 1, prev)) begin
               // A freed slot is preferred; otherwise a never-used one is taken.
               if (free_top != NULL_SLOT && free_top < SLOTS) begin
                  slot     = free_top;
                  free_top = slot_link[slot];
               end else if (next_fresh < SLOTS) begin
                  slot       = POS_W'(next_fresh);
                  next_fresh = next_fresh + 1;
               end else begin
                  res.status = STATUS_FULL;
               end
               if (slot != NULL_SLOT) begin
                  slot_word[slot] = word;
                  slot_link[slot] = slot_link[prev];
                  slot_link[prev] = slot;
                  node_count      = node_count + 1;
                  res.ok          = 1'b1;
                  res.status      = STATUS_DONE;
               end
            end
         end
         CMD_REMOVE: begin
            if (pos >= 1 && follow_links(pos - 1, prev)) begin
               slot = slot_link[prev];
               if (slot != NULL_SLOT && slot < SLOTS) begin
                  slot_link[prev] = slot_link[slot];
                  slot_link[slot] = free_top;
                  free_top        = slot;
                  node_count      = node_count - 1;
                  res.ok          = 1'b1;
                  res.status      = STATUS_DONE;
               end
            end
         end
         CMD_READ: begin
            if (pos >= 1 && follow_links(pos, slot)) begin
               res.read_value = slot_word[slot];
               res.ok         = 1'b1;
               res.status     = STATUS_DONE;
            end
         end
         default: begin
            // An unknown command is rejected as a bad position.
         end
      endcase
      pending_results.push_back(res);
   endfunction

   // Compares one response beat with the oldest prediction, field by field.
   function void check_response(logic ok, logic [STATUS_W-1:0] status,
                                logic [DATA_W-1:0] read_value);
      result_type want;
      if (pending_results.size() == 0) begin
         $error("response beat with no request outstanding");
         fault_count = fault_count + 1;
         return;
      end
      want = pending_results.pop_front();
      if (ok !== want.ok) begin
         $error("ok: expected %0d, got %0d", want.ok, ok);
         fault_count = fault_count + 1;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         fault_count = fault_count + 1;
      end
      if (read_value !== want.read_value) begin
         $error("read_value: expected %h, got %h", want.read_value, read_value);
         fault_count = fault_count + 1;
      end
   endfunction

endclass

module tb_static_linked_list_engine_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int               CAPACITY    = DEFAULT_CAPACITY;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int               PHASE_BEATS = 200;
   localparam int unsigned      CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_ok;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_read_value;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count = 0;
   bit          filling = 1'b1;

   list_mirror #(CAPACITY) mirror;

   static_linked_list_engine_top #(.CAPACITY(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The run is abandoned if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiving side: checks each response beat and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            mirror.check_response(rsp_ok, rsp_status, rsp_read_value);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Presents one request beat after a random gap and waits until it is taken.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_value    <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.note_request(cmd, pos, word);
   endtask

   // Holds the sender back until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (mirror.pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed requests at positions inside the list, with the tide
   // turning between filling the store up to full and draining it to empty.
   task automatic send_mixed_request();
      int unsigned      len;
      int unsigned      roll;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      len = mirror.node_count;
      if (filling && len == CAPACITY - 1 && $urandom_range(3) == 0) begin
         filling = 1'b0;
      end else if (!filling && len == 0 && $urandom_range(1) == 0) begin
         filling = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
         cmd = CMD_W'($urandom_range(3));
         pos = POS_W'($urandom_range(63));
      end else begin
         roll = $urandom_range(99);
         if (roll < 25) begin
            cmd = CMD_READ;
         end else if (filling ? (roll < 81) : (roll < 44)) begin
            cmd = CMD_INSERT;
         end else begin
            cmd = CMD_REMOVE;
         end
         if (cmd == CMD_INSERT) begin
            pos = POS_W'($urandom_range(len + 1, 1));
         end else if (len == 0) begin
            pos = POS_W'(1);
         end else begin
            pos = POS_W'($urandom_range(len, 1));
         end
      end
      send_request(cmd, pos, $urandom());
   endtask

   initial begin
      mirror = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: empty list, both ends, the middle, bad positions,
      // the unknown command and reuse of a freed slot.
      send_request(CMD_READ, 6'd1, 32'h0);
      send_request(CMD_REMOVE, 6'd1, 32'h0);
      send_request(CMD_INSERT, 6'd2, 32'h1234_5678);
      send_request(CMD_INSERT, 6'd0, 32'h1234_5678);
      send_request(CMD_INSERT, 6'd1, 32'h0000_0000);
      send_request(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 6'd3, 32'hA5A5_A5A5);
      send_request(CMD_INSERT, 6'd2, 32'h5A5A_5A5A);
      send_request(CMD_READ, 6'd0, 32'h0);
      send_request(CMD_READ, 6'd1, 32'h0);
      send_request(CMD_READ, 6'd2, 32'h0);
      send_request(CMD_READ, 6'd3, 32'h0);
      send_request(CMD_READ, 6'd4, 32'h0);
      send_request(CMD_READ, 6'd5, 32'h0);
      send_request(CMD_UNKNOWN, 6'd1, 32'hFFFF_FFFF);
      send_request(CMD_REMOVE, 6'd2, 32'h0);
      send_request(CMD_REMOVE, 6'd4, 32'h0);
      send_request(CMD_REMOVE, 6'd0, 32'h0);
      send_request(CMD_REMOVE, 6'd3, 32'h0);
      send_request(CMD_INSERT, 6'd1, 32'hC3C3_C3C3);
      send_request(CMD_READ, 6'd63, 32'h0);
      send_request(CMD_INSERT, 6'd63, 32'hFFFF_FFFF);
      send_request(CMD_READ, 6'd1, 32'h0);
      drain_responses();

      // Random beats under four idling patterns, draining between them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 88;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 88;
            end
            default: begin
               sender_idle_pct    = 34;
               receiver_stall_pct = 34;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) send_mixed_request();
         drain_responses();
      end

      // Allow any stray response beat time to show itself.
      repeat (2 * CAPACITY) @(posedge clock);
      if (mirror.fault_count == 0 && mirror.pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> static_linked_list_engine_top.f
+incdir+hdl
hdl/sll_pkg.sv
hdl/sll_cell.sv
hdl/sll_ctrl.sv
hdl/static_linked_list_engine_top.sv
tb/sv/tb_static_linked_list_engine_top.sv
